// ===== src/ovae_pkg.sv =====
// Package: shared widths and divider handshake types for the optical-flow estimator.
`default_nettype none
package ovae_pkg;
    // dividend magnitude width: |33-bit difference * 1000| stays below 2^43
    localparam int DIV_W  = 43;
    localparam int DVSR_W = 32;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== src/ovae_item_if.sv =====
// Interface: input word channel of the estimator.
`default_nettype none
interface ovae_item_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic               flow_valid;
    logic [31:0]        flow_time;
    logic [31:0]        flow_stamp;
    logic [7:0]         flow_quality;
    logic signed [31:0] flow_x;
    logic signed [31:0] flow_y;
    logic signed [31:0] terrain_dist;

    modport source (output valid, now_ms, flow_valid, flow_time, flow_stamp,
                    flow_quality, flow_x, flow_y, terrain_dist, input ready);
    modport sink (input valid, now_ms, flow_valid, flow_time, flow_stamp,
                  flow_quality, flow_x, flow_y, terrain_dist, output ready);
endinterface
`default_nettype wire

// ===== src/ovae_res_if.sv =====
// Interface: result word channel of the estimator.
`default_nettype none
interface ovae_res_if;
    logic               valid;
    logic               ready;
    logic [10:0]        horiz_conf_scaled;
    logic [10:0]        vert_conf_scaled;
    logic signed [31:0] altitude_mm;
    logic signed [15:0] vel_x_cms;
    logic signed [15:0] vel_y_cms;
    logic signed [15:0] climb_cms;
    logic [31:0]        estimate_time;
    logic               sample_used;

    modport source (output valid, horiz_conf_scaled, vert_conf_scaled, altitude_mm,
                    vel_x_cms, vel_y_cms, climb_cms, estimate_time, sample_used,
                    input ready);
    modport sink (input valid, horiz_conf_scaled, vert_conf_scaled, altitude_mm,
                  vel_x_cms, vel_y_cms, climb_cms, estimate_time, sample_used,
                  output ready);
endinterface
`default_nettype wire

// ===== src/ovae_div.sv =====
// Serial restoring divider: one quotient bit per cycle, unsigned.
`default_nettype none
module ovae_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ovae_pkg::t_div_req i_req,
    output ovae_pkg::t_div_rsp      o_rsp
);
    import ovae_pkg::*;

    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_dvd;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic              r_done;
    logic [DVSR_W:0]   rem_sh;
    logic              take;

    // shift in the next dividend bit and trial-subtract
    assign rem_sh = {r_rem, r_dvd[DIV_W-1]};
    assign take   = rem_sh >= {1'b0, r_dvsr};

    // count down the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= DCNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) r_done <= 1'b1;
            end
        end
    end

    // remainder and quotient datapath; quotient bits fill the dividend register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd  <= i_req.dividend;
            r_dvsr <= i_req.divisor;
            r_rem  <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= take ? DVSR_W'(rem_sh - {1'b0, r_dvsr}) : rem_sh[DVSR_W-1:0];
            r_dvd <= {r_dvd[DIV_W-2:0], take};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;
endmodule
`default_nettype wire

// ===== src/optflow_velocity_altitude_estimator_core.sv =====
// Optical-flow velocity and altitude estimator: sequencer, shared multiplier, outputs.
//
// Usage: each input word on i_item carries the tick, one flow sample and the ground
// distance; exactly one result word leaves on o_res per input word. Configuration
// registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write
// them only while the block is idle, and the block itself does not enforce this.
// One item is handled at a time: i_item.ready is high only while idle. An invalid,
// stale or repeated sample goes from the check step straight to the output steps; an
// update may first run the velocity and altitude filter steps and, when the climb rate
// is divided, waits on the 43-step serial divider. Every product passes through one
// shared 33 x 17 signed multiplier with a registered output, one product per cycle.
// A result word is held in the output register until o_res.ready; the next item is
// taken in the cycle after the result leaves.
// Reset (synchronous, active low) clears all filter states, confidences, the last
// stamp and the last call time to zero and loads the register defaults.
`default_nettype none
module optflow_velocity_altitude_estimator_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ovae_item_if.sink        i_item,
    ovae_res_if.source       o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);
    import ovae_pkg::*;

    localparam logic [2:0] CFG_STALE = 3'd0, CFG_QMIN = 3'd1, CFG_DMIN = 3'd2,
                           CFG_DMAX = 3'd3, CFG_HCOEF = 3'd4, CFG_ACOEF = 3'd5,
                           CFG_CCOEF = 3'd6, CFG_CLIM = 3'd7;

    localparam logic [4:0] S_IDLE = 5'd0, S_CHECK = 5'd1, S_VX_M = 5'd2, S_VX_W = 5'd3,
                           S_VY_W = 5'd4, S_AL_M = 5'd5, S_AL_W = 5'd6, S_DF_M = 5'd7,
                           S_DF_W = 5'd8, S_DV_RUN = 5'd9, S_CL_M = 5'd10,
                           S_CL_W = 5'd11, S_SO_A = 5'd12, S_SO_X = 5'd13,
                           S_SO_Y = 5'd14, S_SO_C = 5'd15, S_SO_E = 5'd16,
                           S_OUT = 5'd17;

    localparam logic signed [49:0] RND = 50'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [16:0] K_MM = 17'sd1000;
    localparam logic signed [16:0] K_CM = 17'sd100;

    // configuration
    logic [15:0] r_stale;
    logic [7:0]  r_qmin;
    logic [30:0] r_dmin, r_dmax;
    logic [15:0] r_hcoef, r_acoef, r_ccoef;
    logic [3:0]  r_clim;

    // state
    logic signed [31:0] r_vx, r_vy, r_alt, r_climb, r_prev, r_rate;
    logic [3:0]  r_hc, r_vc;
    logic [31:0] r_last_stamp, r_last_call, r_dt;
    logic [4:0]  r_state;
    logic        r_v_ema, r_used, r_neg;

    // latched input word
    logic [31:0] r_now, r_ftime, r_stamp;
    logic        r_fvalid;
    logic [7:0]  r_qual;
    logic signed [31:0] r_fx, r_fy, r_gd;

    // result register
    logic signed [31:0] r_o_alt;
    logic signed [15:0] r_o_vx, r_o_vy, r_o_cl;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] r_prod;
    logic signed [49:0] prod_mag;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic ok_flow, dist_ok, qual_ok;

    ovae_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    // truncate a scaled product toward zero
    function automatic logic signed [49:0] trunc_q(input logic signed [49:0] p);
        logic signed [49:0] t;
        t = p[49] ? p + RND : p;
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647)       return 32'sh7FFFFFFF;
        else if (v < -50'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        if (v > 50'sd32767)       return 16'sh7FFF;
        else if (v < -50'sd32768) return 16'sh8000;
        else                      return v[15:0];
    endfunction

    // sample checks on the latched word
    assign ok_flow = r_fvalid && ((r_now - r_ftime) <= {16'b0, r_stale});
    assign qual_ok = r_qual > r_qmin;
    assign dist_ok = ($signed({r_gd[31], r_gd}) > $signed({2'b0, r_dmin})) &&
                     ($signed({r_gd[31], r_gd}) < $signed({2'b0, r_dmax}));

    // select multiplier operands by step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_VX_M: begin mul_a = 33'(r_vx) - 33'(r_fx); mul_b = {1'b0, r_hcoef}; end
            S_VX_W: begin mul_a = 33'(r_vy) - 33'(r_fy); mul_b = {1'b0, r_hcoef}; end
            S_AL_M: begin mul_a = 33'(r_alt) - 33'(r_gd); mul_b = {1'b0, r_acoef}; end
            S_DF_M: begin mul_a = 33'(r_alt) - 33'(r_prev); mul_b = K_MM; end
            S_CL_M: begin mul_a = 33'(r_climb) - 33'(r_rate); mul_b = {1'b0, r_ccoef}; end
            S_SO_A: begin mul_a = 33'(r_alt); mul_b = K_MM; end
            S_SO_X: begin mul_a = 33'(r_vx); mul_b = K_CM; end
            S_SO_Y: begin mul_a = 33'(r_vy); mul_b = K_CM; end
            S_SO_C: begin mul_a = 33'(r_climb); mul_b = K_CM; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 50'(mul_a) * 50'(mul_b);
    end

    assign prod_mag = r_prod[49] ? -r_prod : r_prod;

    // start the divider on the rate difference
    assign div_req.start    = (r_state == S_DF_W);
    assign div_req.dividend = prod_mag[DIV_W-1:0];
    assign div_req.divisor  = r_dt;

    // latch the accepted word
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_now    <= i_item.now_ms;
            r_fvalid <= i_item.flow_valid;
            r_ftime  <= i_item.flow_time;
            r_stamp  <= i_item.flow_stamp;
            r_qual   <= i_item.flow_quality;
            r_fx     <= i_item.flow_x;
            r_fy     <= i_item.flow_y;
            r_gd     <= i_item.terrain_dist;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale <= 16'd200;
            r_qmin  <= 8'd40;
            r_dmin  <= 31'd6554;
            r_dmax  <= 31'd294912;
            r_hcoef <= 16'd39322;
            r_acoef <= 16'd45875;
            r_ccoef <= 16'd58982;
            r_clim  <= 4'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STALE: r_stale <= i_cfg_data[15:0];
                CFG_QMIN:  r_qmin  <= i_cfg_data[7:0];
                CFG_DMIN:  r_dmin  <= i_cfg_data;
                CFG_DMAX:  r_dmax  <= i_cfg_data;
                CFG_HCOEF: r_hcoef <= i_cfg_data[15:0];
                CFG_ACOEF: r_acoef <= i_cfg_data[15:0];
                CFG_CCOEF: r_ccoef <= i_cfg_data[15:0];
                CFG_CLIM:  r_clim  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vx         <= '0;
            r_vy         <= '0;
            r_alt        <= '0;
            r_climb      <= '0;
            r_hc         <= '0;
            r_vc         <= '0;
            r_last_stamp <= '0;
            r_last_call  <= '0;
            r_v_ema      <= 1'b0;
            r_used       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_dt        <= r_now - r_last_call;
                    r_last_call <= r_now;
                    r_used      <= 1'b0;
                    r_v_ema     <= 1'b0;
                    r_state     <= S_SO_A;
                    if (!ok_flow) begin
                        r_hc <= '0;
                        r_vc <= '0;
                    end else if (r_stamp != r_last_stamp) begin
                        r_last_stamp <= r_stamp;
                        r_used       <= 1'b1;
                        // horizontal filter
                        if (qual_ok) begin
                            if (r_hc == '0) begin
                                r_vx <= r_fx;
                                r_vy <= r_fy;
                            end
                            if (r_hc < r_clim) r_hc <= r_hc + 1'b1;
                        end else begin
                            r_vx <= '0;
                            r_vy <= '0;
                            r_hc <= '0;
                        end
                        // altitude filter
                        if (dist_ok) begin
                            if (r_vc != '0) begin
                                r_v_ema <= 1'b1;
                            end else begin
                                r_alt   <= r_gd;
                                r_climb <= '0;
                            end
                            if (r_vc < r_clim) r_vc <= r_vc + 1'b1;
                        end else begin
                            r_alt   <= '0;
                            r_climb <= '0;
                            r_vc    <= '0;
                        end
                        if (qual_ok && r_hc != '0)       r_state <= S_VX_M;
                        else if (dist_ok && r_vc != '0)  r_state <= S_AL_M;
                    end
                end
                S_VX_M: r_state <= S_VX_W;
                S_VX_W: begin
                    r_vx    <= r_fx + r_prod[47:16];
                    r_state <= S_VY_W;
                end
                S_VY_W: begin
                    r_vy    <= r_fy + r_prod[47:16];
                    r_state <= r_v_ema ? S_AL_M : S_SO_A;
                end
                S_AL_M: begin
                    r_prev  <= r_alt;
                    r_state <= S_AL_W;
                end
                S_AL_W: begin
                    r_alt <= r_gd + r_prod[47:16];
                    if (r_dt == '0) begin
                        r_rate  <= '0;
                        r_state <= S_CL_M;
                    end else begin
                        r_state <= S_DF_M;
                    end
                end
                S_DF_M: r_state <= S_DF_W;
                S_DF_W: begin
                    r_neg   <= r_prod[49];
                    r_state <= S_DV_RUN;
                end
                S_DV_RUN: begin
                    if (div_rsp.done) begin
                        // saturate the signed quotient to int32
                        if (r_neg) begin
                            r_rate <= (div_rsp.quot > 43'h0_8000_0000) ? 32'sh80000000
                                      : 32'(-div_rsp.quot[31:0]);
                        end else begin
                            r_rate <= (div_rsp.quot > 43'h0_7FFF_FFFF) ? 32'sh7FFFFFFF
                                      : div_rsp.quot[31:0];
                        end
                        r_state <= S_CL_M;
                    end
                end
                S_CL_M: r_state <= S_CL_W;
                S_CL_W: begin
                    r_climb <= r_rate + r_prod[47:16];
                    r_state <= S_SO_A;
                end
                S_SO_A: r_state <= S_SO_X;
                S_SO_X: begin
                    r_o_alt <= sat32(trunc_q(r_prod));
                    r_state <= S_SO_Y;
                end
                S_SO_Y: begin
                    r_o_vx  <= sat16(trunc_q(r_prod));
                    r_state <= S_SO_C;
                end
                S_SO_C: begin
                    r_o_vy  <= sat16(trunc_q(r_prod));
                    r_state <= S_SO_E;
                end
                S_SO_E: begin
                    r_o_cl  <= sat16(trunc_q(r_prod));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ports
    assign i_item.ready            = (r_state == S_IDLE);
    assign o_res.valid             = (r_state == S_OUT);
    assign o_res.horiz_conf_scaled = 11'(r_hc) * 11'd100;
    assign o_res.vert_conf_scaled  = 11'(r_vc) * 11'd100;
    assign o_res.altitude_mm       = r_o_alt;
    assign o_res.vel_x_cms         = r_o_vx;
    assign o_res.vel_y_cms         = r_o_vy;
    assign o_res.climb_cms         = r_o_cl;
    assign o_res.estimate_time     = r_now;
    assign o_res.sample_used       = r_used;

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_item.ready)
        else $error("input taken while a result word waits");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DV_RUN))
        else $error("divider finished outside its wait step");
    a_out_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after the result word");
    a_conf_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CHECK) |=> ($stable(r_hc) && $stable(r_vc)))
        else $error("confidence changed outside the check step");
endmodule
`default_nettype wire

// ===== tb/tb_optflow_velocity_altitude_estimator_core.sv =====
// Testbench: random and directed flow samples checked against an in-bench estimator model.
`timescale 1ns / 100ps
`default_nettype none
module tb_optflow_velocity_altitude_estimator_core;
    localparam int FRAC = 16;
    localparam int ONE  = 65536;
    localparam int WDOG_LIMIT = 20000;

    typedef enum logic [2:0] {
        REG_STALE = 3'd0, REG_QMIN = 3'd1, REG_DMIN = 3'd2, REG_DMAX = 3'd3,
        REG_HCOEF = 3'd4, REG_ACOEF = 3'd5, REG_CCOEF = 3'd6, REG_CLIM = 3'd7
    } t_reg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               flow_valid;
        logic [31:0]        flow_time;
        logic [31:0]        flow_stamp;
        logic [7:0]         flow_quality;
        logic signed [31:0] flow_x;
        logic signed [31:0] flow_y;
        logic signed [31:0] terrain_dist;
    } t_sample;

    typedef struct packed {
        logic [10:0]        hconf;
        logic [10:0]        vconf;
        logic signed [31:0] alt_mm;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] climb;
        logic [31:0]        est_time;
        logic               used;
    } t_estimate;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [30:0] i_cfg_data;

    ovae_item_if item_ch();
    ovae_res_if  res_ch();

    optflow_velocity_altitude_estimator_core #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .o_res(res_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // estimator model state and registers
    logic [15:0] m_stale;
    logic [7:0]  m_qmin;
    logic [30:0] m_dmin, m_dmax;
    logic [15:0] m_hcoef, m_acoef, m_ccoef;
    logic [3:0]  m_clim;
    logic signed [31:0] m_vx, m_vy, m_alt, m_climb;
    logic [3:0]  m_hconf, m_vconf;
    logic [31:0] m_last_stamp, m_last_call;

    t_sample   sample_q[$];
    t_estimate estimate_q[$];
    int        n_mismatch;
    int        idle_cycles;
    bit        stim_done;
    bit        hold_off;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint floor_div16(longint x);
        if (x >= 0) return x / ONE;
        return -((-x + ONE - 1) / ONE);
    endfunction

    function automatic logic signed [31:0] ema_step(logic signed [31:0] x,
                                                    logic signed [31:0] st,
                                                    logic [15:0] c);
        longint s;
        s = longint'(ONE - int'(c)) * longint'(x) + longint'(c) * longint'(st);
        return 32'(floor_div16(s));
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint to_units(logic signed [31:0] v, longint k);
        return (longint'(v) * k) / (longint'(1) << FRAC);
    endfunction

    task automatic model_reset();
        m_stale = 16'd200; m_qmin = 8'd40; m_dmin = 31'd6554; m_dmax = 31'd294912;
        m_hcoef = 16'd39322; m_acoef = 16'd45875; m_ccoef = 16'd58982; m_clim = 4'd10;
        m_vx = 0; m_vy = 0; m_alt = 0; m_climb = 0;
        m_hconf = 0; m_vconf = 0; m_last_stamp = 0; m_last_call = 0;
    endtask

    // predict the estimate for one accepted word
    function automatic t_estimate predict_estimate(t_sample s);
        t_estimate e;
        logic [31:0] dt;
        logic signed [31:0] prev;
        longint rate;
        longint gd;
        dt = s.now_ms - m_last_call;
        m_last_call = s.now_ms;
        e.used = 1'b0;
        if (!s.flow_valid || (s.now_ms - s.flow_time) > {16'd0, m_stale}) begin
            m_hconf = 0;
            m_vconf = 0;
        end else if (s.flow_stamp != m_last_stamp) begin
            m_last_stamp = s.flow_stamp;
            e.used = 1'b1;
            if (s.flow_quality > m_qmin) begin
                if (m_hconf > 0) begin
                    m_vx = ema_step(s.flow_x, m_vx, m_hcoef);
                    m_vy = ema_step(s.flow_y, m_vy, m_hcoef);
                end else begin
                    m_vx = s.flow_x;
                    m_vy = s.flow_y;
                end
                if (m_hconf < m_clim) m_hconf++;
            end else begin
                m_vx = 0; m_vy = 0; m_hconf = 0;
            end
            gd = longint'(s.terrain_dist);
            if (gd > longint'(m_dmin) && gd < longint'(m_dmax)) begin
                prev = m_alt;
                if (m_vconf > 0) begin
                    rate = 0;
                    m_alt = ema_step(s.terrain_dist, m_alt, m_acoef);
                    if (dt != 0)
                        rate = clamp(((longint'(m_alt) - longint'(prev)) * 1000)
                                     / longint'({32'd0, dt}),
                                     -64'sd2147483648, 64'sd2147483647);
                    m_climb = ema_step(32'(rate), m_climb, m_ccoef);
                end else begin
                    m_alt = s.terrain_dist;
                    m_climb = 0;
                end
                if (m_vconf < m_clim) m_vconf++;
            end else begin
                m_alt = 0; m_climb = 0; m_vconf = 0;
            end
        end
        e.hconf    = 11'(m_hconf * 100);
        e.vconf    = 11'(m_vconf * 100);
        e.alt_mm   = 32'(clamp(to_units(m_alt, 1000), -64'sd2147483648, 64'sd2147483647));
        e.vx       = 16'(clamp(to_units(m_vx, 100), -32768, 32767));
        e.vy       = 16'(clamp(to_units(m_vy, 100), -32768, 32767));
        e.climb    = 16'(clamp(to_units(m_climb, 100), -32768, 32767));
        e.est_time = s.now_ms;
        return e;
    endfunction

    task automatic write_reg(t_reg r, logic [30:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (r)
            REG_STALE: m_stale = v[15:0];
            REG_QMIN:  m_qmin  = v[7:0];
            REG_DMIN:  m_dmin  = v;
            REG_DMAX:  m_dmax  = v;
            REG_HCOEF: m_hcoef = v[15:0];
            REG_ACOEF: m_acoef = v[15:0];
            REG_CCOEF: m_ccoef = v[15:0];
            default:   m_clim  = v[3:0];
        endcase
    endtask

    // wait for the block to drain, then allow for its longest latency
    task automatic wait_idle();
        while (sample_q.size() != 0 || estimate_q.size() != 0 || item_ch.valid)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // stimulus generation keeps a running tick so most samples are fresh
    logic [31:0] gen_now;
    logic [31:0] gen_stamp;

    function automatic t_sample rand_sample(bit well_formed);
        t_sample s;
        gen_now = gen_now + $urandom_range(0, 60);
        s.now_ms = gen_now;
        s.flow_valid = well_formed ? ($urandom_range(0, 19) != 0) : 1'($urandom);
        s.flow_time = well_formed ? gen_now - $urandom_range(0, 250) : $urandom;
        if (well_formed && $urandom_range(0, 9) != 0) gen_stamp = gen_stamp + $urandom_range(1, 5000);
        else if (!well_formed) gen_stamp = $urandom;
        s.flow_stamp = gen_stamp;
        s.flow_quality = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            s.flow_x = $urandom;
            s.flow_y = $urandom;
        end else begin
            s.flow_x = $signed($urandom_range(0, 600000)) - 300000;
            s.flow_y = $signed($urandom_range(0, 600000)) - 300000;
        end
        if (well_formed && $urandom_range(0, 4) != 0)
            s.terrain_dist = $urandom_range(1000, 320000);
        else
            s.terrain_dist = $urandom;
        return s;
    endfunction

    // driver: present queued words with random gaps
    int drv_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            drv_gap <= 0;
        end else if (item_ch.valid && !item_ch.ready) begin
            // hold the word until taken
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                estimate_q.push_back(predict_estimate(sample_q.pop_front()));
            end
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                item_ch.valid <= 1'b0;
            end else if (sample_q.size() > (item_ch.valid && item_ch.ready ? 0 : 0) &&
                         !(item_ch.valid && item_ch.ready && sample_q.size() == 0)) begin
                item_ch.valid        <= 1'b1;
                item_ch.now_ms       <= sample_q[0].now_ms;
                item_ch.flow_valid   <= sample_q[0].flow_valid;
                item_ch.flow_time    <= sample_q[0].flow_time;
                item_ch.flow_stamp   <= sample_q[0].flow_stamp;
                item_ch.flow_quality <= sample_q[0].flow_quality;
                item_ch.flow_x       <= sample_q[0].flow_x;
                item_ch.flow_y       <= sample_q[0].flow_y;
                item_ch.terrain_dist <= sample_q[0].terrain_dist;
                drv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest estimate
    int mon_gap;
    always @(posedge i_clk) begin
        t_estimate exp_e;
        t_estimate got;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            mon_gap <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.horiz_conf_scaled, res_ch.vert_conf_scaled, res_ch.altitude_mm,
                        res_ch.vel_x_cms, res_ch.vel_y_cms, res_ch.climb_cms,
                        res_ch.estimate_time, res_ch.sample_used};
                if (estimate_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected word %p", got);
                end else begin
                    exp_e = estimate_q.pop_front();
                    if (got !== exp_e) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) $display("expected %p\n  actual %p", exp_e, got);
                    end
                end
                mon_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
                res_ch.ready <= 1'b0;
            end else if (hold_off) begin
                res_ch.ready <= 1'b0;
            end else if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || !(item_ch.valid || estimate_q.size() != 0) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("optflow_velocity_altitude_estimator_core: mismatch");
            $finish;
        end
    end

    // long receiver stall while the sender keeps offering words
    initial begin
        hold_off = 1'b0;
        wait (stim_done == 1'b0 && sample_q.size() > 20);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic queue_set(int n, int well_pct);
        repeat (n) sample_q.push_back(rand_sample($urandom_range(0, 99) < well_pct));
    endtask

    initial begin
        t_sample s;
        n_mismatch = 0;
        stim_done = 1'b0;
        gen_now = 32'd1000;
        gen_stamp = 32'd1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_STALE;
        i_cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.now_ms = '0; item_ch.flow_valid = 1'b0; item_ch.flow_time = '0;
        item_ch.flow_stamp = '0; item_ch.flow_quality = '0; item_ch.flow_x = '0;
        item_ch.flow_y = '0; item_ch.terrain_dist = '0;
        res_ch.ready = 1'b0;
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stamp zero after reset, invalid, stale, extremes, repeated stamp
        s = '{32'd100, 1'b1, 32'd100, 32'd0, 8'd255, 32'sd65536, -32'sd65536, 32'sd65536};
        sample_q.push_back(s);
        s.flow_stamp = 32'd7; s.now_ms = 32'd120; s.flow_time = 32'd120;
        sample_q.push_back(s);
        s.now_ms = 32'd140; sample_q.push_back(s);
        s.flow_stamp = 32'd8; s.flow_x = 32'h7FFFFFFF; s.flow_y = 32'h80000000;
        s.terrain_dist = 32'sd200000; sample_q.push_back(s);
        s.flow_stamp = 32'd9; s.now_ms = 32'd140; sample_q.push_back(s);
        s.flow_stamp = 32'd10; s.now_ms = 32'd500; s.flow_time = 32'd200;
        sample_q.push_back(s);
        s.flow_valid = 1'b0; s.flow_stamp = 32'd11; s.flow_time = 32'd500;
        sample_q.push_back(s);
        s.flow_valid = 1'b1; s.flow_quality = 8'd40; s.flow_stamp = 32'd12;
        s.terrain_dist = 32'h80000000; sample_q.push_back(s);
        s.flow_quality = 8'd41; s.flow_stamp = 32'd13; s.terrain_dist = 32'h7FFFFFFF;
        sample_q.push_back(s);
        s.flow_stamp = 32'hFFFFFFFF; s.terrain_dist = 32'sd6555; s.now_ms = 32'hFFFFFFFF;
        s.flow_time = 32'hFFFFFFFF; s.flow_x = -32'sd1; s.flow_y = 32'sd1;
        sample_q.push_back(s);
        s.flow_stamp = 32'd14; s.terrain_dist = 32'sd294911; s.now_ms = 32'd3;
        s.flow_time = 32'hFFFFFF00; sample_q.push_back(s);
        s.flow_stamp = 32'd15; s.flow_quality = 8'd0; s.terrain_dist = 32'sd6554;
        s.flow_time = 32'd3; sample_q.push_back(s);
        wait_idle();

        // random phases across register settings, extremes included
        queue_set(350, 85);
        wait_idle();
        write_reg(REG_STALE, 31'd65535); write_reg(REG_QMIN, 31'd0);
        write_reg(REG_DMIN, 31'd0); write_reg(REG_DMAX, 31'h7FFFFFFF);
        write_reg(REG_HCOEF, 31'd65535); write_reg(REG_ACOEF, 31'd0);
        write_reg(REG_CCOEF, 31'd65535); write_reg(REG_CLIM, 31'd15);
        gen_now = gen_now + 32'd1000;
        queue_set(400, 85);
        wait_idle();
        write_reg(REG_STALE, 31'd0); write_reg(REG_QMIN, 31'd255);
        write_reg(REG_HCOEF, 31'd0); write_reg(REG_ACOEF, 31'd65535);
        write_reg(REG_CCOEF, 31'd0); write_reg(REG_CLIM, 31'd2);
        queue_set(300, 85);
        wait_idle();
        write_reg(REG_STALE, 31'd30); write_reg(REG_QMIN, 31'd128);
        write_reg(REG_DMIN, 31'd50000); write_reg(REG_DMAX, 31'd250000);
        write_reg(REG_HCOEF, 31'($urandom)); write_reg(REG_ACOEF, 31'($urandom));
        write_reg(REG_CCOEF, 31'($urandom)); write_reg(REG_CLIM, 31'd0);
        queue_set(300, 80);
        wait_idle();
        write_reg(REG_STALE, 31'd200); write_reg(REG_QMIN, 31'd40);
        write_reg(REG_DMIN, 31'd6554); write_reg(REG_DMAX, 31'd294912);
        write_reg(REG_HCOEF, 31'd39322); write_reg(REG_ACOEF, 31'd45875);
        write_reg(REG_CCOEF, 31'd58982); write_reg(REG_CLIM, 31'd10);
        queue_set(580, 90);
        stim_done = 1'b1;
        wait_idle();

        if (n_mismatch == 0 && estimate_q.size() == 0)
            $display("optflow_velocity_altitude_estimator_core: match");
        else
            $display("optflow_velocity_altitude_estimator_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
